// ===== src/ftwm_pkg.sv =====
// package: shared constants, payload types and handoff struct for the frame time window monitor
`default_nettype none
package ftwm_pkg;
  localparam int WindowDepth = 128;
  localparam int SlotW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int CountW = $clog2(WindowDepth + 1);
  localparam int SumW = 16 + CountW;
  localparam int RateW = 26;
  localparam logic [RateW-1:0] RateNum = RateW'(65536000);
  localparam int DivW = (SumW > RateW) ? SumW : RateW;
  localparam int DivCntW = $clog2(DivW + 1);

  typedef struct packed {
    logic [15:0] cpu_time;
    logic [15:0] gpu_time;
    logic [15:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] current_cpu;
    logic [15:0] current_gpu;
    logic [15:0] average_cpu;
    logic [15:0] average_gpu;
    logic [15:0] worst_cpu;
    logic [15:0] worst_gpu;
    logic [25:0] current_rate;
    logic [25:0] worst_rate;
    logic        warmup_done;
    logic [31:0] elapsed_time;
    logic [7:0]  sample_count;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    logic [15:0]       cpu;
    logic [15:0]       gpu;
    logic [SumW-1:0]   cpu_sum;
    logic [SumW-1:0]   gpu_sum;
    logic [CountW-1:0] count;
    logic [15:0]       peak_cpu;
    logic [15:0]       peak_gpu;
    logic              done;
    logic [31:0]       total;
  } job_t;
endpackage
`default_nettype wire

// ===== src/ftwm_front.sv =====
// front part: window rings, running sums, elapsed time and peak hold
`default_nettype none
module ftwm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [31:0]         warmup_time,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ftwm_pkg::in_item_t  in_data,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output ftwm_pkg::job_t           job
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state, state_next;
  logic [15:0] cpu_mem [ftwm_pkg::WindowDepth];
  logic [15:0] gpu_mem [ftwm_pkg::WindowDepth];
  logic [15:0] old_cpu, old_gpu;
  logic [ftwm_pkg::SlotW-1:0] slot;
  logic [ftwm_pkg::CountW-1:0] count;
  logic [ftwm_pkg::SumW-1:0] cpu_sum, gpu_sum;
  logic [15:0] peak_cpu, peak_gpu;
  logic [31:0] total;
  ftwm_pkg::in_item_t item;
  logic full;
  logic [32:0] total_sum;
  logic [31:0] total_new;
  logic [ftwm_pkg::SumW-1:0] cpu_sum_next, gpu_sum_next;
  logic done;

  assign full = (count == ftwm_pkg::CountW'(ftwm_pkg::WindowDepth));
  assign total_sum = {1'b0, total} + {17'd0, item.delta_time};
  assign total_new = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
  assign done = (total_new >= warmup_time);
  assign cpu_sum_next = cpu_sum + ftwm_pkg::SumW'(item.cpu_time)
                        - (full ? ftwm_pkg::SumW'(old_cpu) : '0);
  assign gpu_sum_next = gpu_sum + ftwm_pkg::SumW'(item.gpu_time)
                        - (full ? ftwm_pkg::SumW'(old_gpu) : '0);

  assign in_ready = (state == S_IDLE);
  assign job_valid = (state == S_SEND);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_SEND;
      S_SEND: if (job_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ring read of the oldest entry, and write of the new entry in the read state
  always_ff @(posedge clk) begin
    old_cpu <= cpu_mem[slot];
    old_gpu <= gpu_mem[slot];
    if (state == S_READ) begin
      cpu_mem[slot] <= item.cpu_time;
      gpu_mem[slot] <= item.gpu_time;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      count <= '0;
      cpu_sum <= '0;
      gpu_sum <= '0;
      peak_cpu <= '0;
      peak_gpu <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      if (state == S_READ) begin
        // old entry read in idle is still valid here: slot unchanged
        total <= total_new;
        cpu_sum <= cpu_sum_next;
        gpu_sum <= gpu_sum_next;
        if (!full) count <= count + 1'b1;
        slot <= (slot == ftwm_pkg::SlotW'(ftwm_pkg::WindowDepth - 1)) ? '0 : slot + 1'b1;
        job.cpu <= item.cpu_time;
        job.gpu <= item.gpu_time;
        job.cpu_sum <= cpu_sum_next;
        job.gpu_sum <= gpu_sum_next;
        job.count <= full ? count : count + 1'b1;
        job.done <= done;
        job.total <= total_new;
        job.peak_cpu <= (done && item.cpu_time > peak_cpu) ? item.cpu_time : peak_cpu;
        job.peak_gpu <= (done && item.gpu_time > peak_gpu) ? item.gpu_time : peak_gpu;
        if (done && item.cpu_time > peak_cpu) peak_cpu <= item.cpu_time;
        if (done && item.gpu_time > peak_gpu) peak_gpu <= item.gpu_time;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ftwm_queue.sv =====
// two-entry queue between the front and back parts
`default_nettype none
module ftwm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire ftwm_pkg::job_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output ftwm_pkg::job_t      rd_data
);
  ftwm_pkg::job_t mem [2];
  logic wptr, rptr;
  logic [1:0] fill;
  logic do_wr, do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data = mem[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

// ===== src/ftwm_div.sv =====
// restoring divider, one quotient bit a cycle
`default_nettype none
module ftwm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ftwm_pkg::DivW-1:0]     dividend,
  input  wire logic [ftwm_pkg::DivW-1:0]     divisor,
  output logic                               busy,
  output logic [ftwm_pkg::DivW-1:0]          quotient
);
  logic [ftwm_pkg::DivW-1:0] rem, den;
  logic [ftwm_pkg::DivCntW-1:0] cnt;
  logic [ftwm_pkg::DivW:0] trial;

  assign trial = {rem, quotient[ftwm_pkg::DivW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= ftwm_pkg::DivCntW'(ftwm_pkg::DivW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ftwm_pkg::DivCntW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[ftwm_pkg::DivW]) begin
        rem <= trial[ftwm_pkg::DivW-1:0];
        quotient <= {quotient[ftwm_pkg::DivW-2:0], 1'b1};
      end else begin
        rem <= {rem[ftwm_pkg::DivW-2:0], quotient[ftwm_pkg::DivW-1]};
        quotient <= {quotient[ftwm_pkg::DivW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ftwm_back.sv =====
// back part: four divisions through one shared divider, then the result register
`default_nettype none
module ftwm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  output logic                     job_ready,
  input  wire ftwm_pkg::job_t      job,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ftwm_pkg::out_item_t      out_data
);
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_KICK = 4'b0010,
    B_WAIT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state;
  ftwm_pkg::job_t cur;
  logic [1:0] op;
  logic start, busy;
  logic [ftwm_pkg::DivW-1:0] dvd, dvs, quo;
  logic [15:0] worst;

  assign worst = (cur.peak_cpu > cur.peak_gpu) ? cur.peak_cpu : cur.peak_gpu;
  assign job_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign start = (state == B_KICK);

  always_comb begin
    case (op)
      2'd0: begin
        dvd = ftwm_pkg::DivW'(cur.cpu_sum);
        dvs = ftwm_pkg::DivW'(cur.count);
      end
      2'd1: begin
        dvd = ftwm_pkg::DivW'(cur.gpu_sum);
        dvs = ftwm_pkg::DivW'(cur.count);
      end
      2'd2: begin
        dvd = ftwm_pkg::DivW'(ftwm_pkg::RateNum);
        dvs = ftwm_pkg::DivW'(cur.cpu);
      end
      default: begin
        dvd = ftwm_pkg::DivW'(ftwm_pkg::RateNum);
        dvs = ftwm_pkg::DivW'(worst);
      end
    endcase
  end

  ftwm_div u_div (
    .clk(clk), .rst(rst), .start(start), .dividend(dvd), .divisor(dvs),
    .busy(busy), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      op <= '0;
    end else begin
      unique case (state)
        B_IDLE: if (job_valid) begin
          state <= B_KICK;
          op <= '0;
        end
        B_KICK: state <= B_WAIT;
        B_WAIT: if (!busy) begin
          op <= op + 1'b1;
          state <= (op == 2'd3) ? B_OUT : B_KICK;
        end
        B_OUT: if (out_ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && job_valid) begin
      cur <= job;
      out_data.current_cpu <= job.cpu;
      out_data.current_gpu <= job.gpu;
      out_data.worst_cpu <= job.peak_cpu;
      out_data.worst_gpu <= job.peak_gpu;
      out_data.warmup_done <= job.done;
      out_data.elapsed_time <= job.total;
      out_data.sample_count <= 8'(job.count);
    end
    if (state == B_WAIT && !busy) begin
      case (op)
        2'd0: out_data.average_cpu <= quo[15:0];
        2'd1: out_data.average_gpu <= quo[15:0];
        2'd2: out_data.current_rate <= (dvs == '0) ? '0 : quo[ftwm_pkg::RateW-1:0];
        default: out_data.worst_rate <= (dvs == '0) ? '0 : quo[ftwm_pkg::RateW-1:0];
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/frame_time_window_monitor.sv =====
// top level: frame time window monitor
// path of an accepted input item to its result: the front (read and send states), the queue,
// then the back (four divider passes, then the result register)
// throughput is set by the single shared bit-serial divider
// the front takes the next item while the back still divides, through a two-entry queue
// reset: synchronous active-high rst clears sums, counts, peaks, elapsed time and warmup_time
`default_nettype none
module frame_time_window_monitor (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ftwm_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ftwm_pkg::out_item_t       out_data
);
  // warmup threshold register, always writable
  logic [31:0] warmup_time;
  logic f_valid, f_ready, q_valid, q_ready;
  ftwm_pkg::job_t f_job, q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) warmup_time <= '0;
    else if (cfg_valid) warmup_time <= cfg_data;
  end

  // front: ring update, sums, elapsed time, peaks
  ftwm_front u_front (
    .clk(clk), .rst(rst), .warmup_time(warmup_time),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // decoupling queue
  ftwm_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  // back: averages and rates, result register
  ftwm_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== src/ftwm_checker.sv =====
// port-level checker for the frame time window monitor, with its bind
`default_nettype none
module ftwm_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ftwm_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.sample_count != 8'd0)
    else $error("empty window reported");
  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sample_count == 8'd1 |->
      out_data.average_cpu == out_data.current_cpu)
    else $error("single sample average wrong");
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.current_cpu == 16'd0 |-> out_data.current_rate == 26'd0)
    else $error("zero time gave nonzero rate");
endmodule

bind frame_time_window_monitor ftwm_checker u_ftwm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== bench/frame_time_window_monitor_test.sv =====
// testbench for the frame time window monitor: predicted results checked item by item
module frame_time_window_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = ftwm_pkg::WindowDepth;
  localparam int StallLimit = 20000;

  // predicts window averages, peaks and rates, and holds the results still owed
  class frame_stats_board;
    logic [31:0] warmup;
    logic [15:0] cpu_ring[Depth];
    logic [15:0] gpu_ring[Depth];
    int unsigned slot;
    int unsigned count;
    longint unsigned cpu_total;
    longint unsigned gpu_total;
    logic [15:0] peak_c;
    logic [15:0] peak_g;
    logic [31:0] elapsed;
    ftwm_pkg::out_item_t owed[$];
    int errors;

    function void clear();
      warmup = '0;
      slot = 0;
      count = 0;
      cpu_total = 0;
      gpu_total = 0;
      peak_c = '0;
      peak_g = '0;
      elapsed = '0;
      owed.delete();
      errors = 0;
    endfunction

    function logic [25:0] fps(logic [15:0] t);
      if (t == 0) return '0;
      return 26'(32'd65536000 / t);
    endfunction

    function void note_frame(ftwm_pkg::in_item_t it);
      longint unsigned sum;
      ftwm_pkg::out_item_t r;
      logic [15:0] worst;
      sum = longint'(elapsed) + it.delta_time;
      elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      if (count >= Depth) begin
        cpu_total -= cpu_ring[slot];
        gpu_total -= gpu_ring[slot];
      end else begin
        count++;
      end
      cpu_ring[slot] = it.cpu_time;
      gpu_ring[slot] = it.gpu_time;
      cpu_total += it.cpu_time;
      gpu_total += it.gpu_time;
      slot = (slot + 1) % Depth;
      r.warmup_done = (elapsed >= warmup);
      if (r.warmup_done) begin
        if (it.cpu_time > peak_c) peak_c = it.cpu_time;
        if (it.gpu_time > peak_g) peak_g = it.gpu_time;
      end
      worst = (peak_c > peak_g) ? peak_c : peak_g;
      r.current_cpu = it.cpu_time;
      r.current_gpu = it.gpu_time;
      r.average_cpu = 16'(cpu_total / count);
      r.average_gpu = 16'(gpu_total / count);
      r.worst_cpu = peak_c;
      r.worst_gpu = peak_g;
      r.current_rate = fps(it.cpu_time);
      r.worst_rate = fps(worst);
      r.elapsed_time = elapsed;
      r.sample_count = 8'(count);
      owed.insert(owed.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(ftwm_pkg::out_item_t g);
      ftwm_pkg::out_item_t e;
      if (owed.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      e = owed[0];
      owed.delete(0);
      if (g.current_cpu !== e.current_cpu) report("current_cpu", g.current_cpu, e.current_cpu);
      if (g.current_gpu !== e.current_gpu) report("current_gpu", g.current_gpu, e.current_gpu);
      if (g.average_cpu !== e.average_cpu) report("average_cpu", g.average_cpu, e.average_cpu);
      if (g.average_gpu !== e.average_gpu) report("average_gpu", g.average_gpu, e.average_gpu);
      if (g.worst_cpu !== e.worst_cpu) report("worst_cpu", g.worst_cpu, e.worst_cpu);
      if (g.worst_gpu !== e.worst_gpu) report("worst_gpu", g.worst_gpu, e.worst_gpu);
      if (g.current_rate !== e.current_rate)
        report("current_rate", g.current_rate, e.current_rate);
      if (g.worst_rate !== e.worst_rate) report("worst_rate", g.worst_rate, e.worst_rate);
      if (g.warmup_done !== e.warmup_done) report("warmup_done", g.warmup_done, e.warmup_done);
      if (g.elapsed_time !== e.elapsed_time)
        report("elapsed_time", g.elapsed_time, e.elapsed_time);
      if (g.sample_count !== e.sample_count)
        report("sample_count", g.sample_count, e.sample_count);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  ftwm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ftwm_pkg::out_item_t out_data;

  frame_stats_board board = new();
  bit calm = 1'b0;      // no idling on either side while set
  int hold_off = 0;     // receiver holds off for this many cycles when set
  int quiet = 0;        // cycles without any accepted item

  always #4 clk = ~clk;

  frame_time_window_monitor DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // receiving side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // watchdog on cycles with no accepted item of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rst || hold_off > 0)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one frame offered until accepted, with occasional idle cycles before it unless calm is set
  // valid stays up after acceptance until the next frame or an explicit idle
  task send_frame(logic [15:0] c, logic [15:0] g, logic [15:0] d);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cpu_time: c, gpu_time: g, delta_time: d};
    do @(posedge clk); while (!in_ready);
    board.note_frame(in_data);
  endtask

  // warmup threshold written only with nothing in flight
  task set_warmup(logic [31:0] v);
    in_valid <= 1'b0;
    wait (board.owed.size() == 0);
    repeat (150) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.warmup = v;
    cfg_valid <= 1'b0;
  endtask

  // mostly small times, sometimes the full range
  function logic [15:0] pick_time();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1000, 12000));
    endcase
  endfunction

  initial begin
    board.clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: warmup at reset value zero, field extremes, zero times
    send_frame(16'h0000, 16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(16'h0001, 16'h0001, 16'h0001);
    send_frame(16'h0000, 16'hFFFF, 16'h0000);
    send_frame(16'hAAAA, 16'h5555, 16'h5555);
    send_frame(16'h5555, 16'hAAAA, 16'hAAAA);

    // warmup set ahead of the elapsed time, and not yet reached by these frames
    set_warmup(32'h0003_0000 + board.elapsed);
    send_frame(16'h4000, 16'h3000, 16'h0000);
    send_frame(16'h4100, 16'h3100, 16'hFFFF);
    send_frame(16'h0200, 16'h0300, 16'hFFFF);
    send_frame(16'h0210, 16'h0310, 16'h0002);
    send_frame(16'h0220, 16'h0320, 16'h0100);

    // maximum threshold: only a saturated elapsed time meets it
    set_warmup(32'hFFFF_FFFF);
    calm = 1'b1;
    for (int i = 0; i < 140; i++) send_frame(pick_time(), pick_time(), 16'h0000);
    calm = 1'b0;

    // random frames; a long receiver hold-off fills the block partway through
    for (int i = 0; i < 250; i++) begin
      if (i == 60) set_warmup($urandom);
      if (i == 120) set_warmup(32'h0);
      if (i == 90) hold_off = 1500;
      calm = (i >= 150 && i < 200);
      send_frame(pick_time(), pick_time(),
                 ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
    end
    calm = 1'b0;

    // top threshold again: peaks stay held while warmup is out of reach
    set_warmup(32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) send_frame(16'($urandom), 16'($urandom), 16'($urandom));
    in_valid <= 1'b0;

    wait (board.owed.size() == 0);
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
